@@ rtl/utf_pkg.sv @@
// ----------------------------------------------------------------------------
// utf_pkg
// Types, constants and byte tables shared by the UTF-8 umlaut transcoder.
// ----------------------------------------------------------------------------
package utf_pkg;

  localparam int NUM_LETTERS = 7;
  localparam int ENT_CHARS   = 5;

  localparam logic [7:0] LEAD_BYTE = 8'hC3;
  localparam logic [7:0] AMP_BYTE  = 8'h26;
  localparam logic [7:0] SEMI_BYTE = 8'h3B;

  // Last index of an entity run for a four-letter and a five-letter name.
  localparam logic [2:0] ENT_LAST_SHORT = 3'd5;
  localparam logic [2:0] ENT_LAST_LONG  = 3'd6;
  localparam logic [2:0] SZLIG_LETTER   = 3'd6;

  localparam logic [2:0] CFG_OUTPUT_FORM = 3'd0;

  localparam logic [7:0] TRAIL_CODE [NUM_LETTERS] =
    '{8'd164, 8'd182, 8'd188, 8'd132, 8'd150, 8'd156, 8'd159};
  localparam logic [7:0] ISO_CODE [NUM_LETTERS] =
    '{8'd228, 8'd246, 8'd252, 8'd196, 8'd214, 8'd220, 8'd223};
  localparam logic [7:0] ENT_TEXT [NUM_LETTERS][ENT_CHARS] = '{
    '{8'h61, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h6F, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h75, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h41, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h4F, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h55, 8'h75, 8'h6D, 8'h6C, 8'h00},
    '{8'h73, 8'h7A, 8'h6C, 8'h69, 8'h67}
  };

  typedef struct packed {
    logic       entity;
    logic       prefix;
    logic [2:0] letter;
    logic [7:0] data;
    logic [2:0] last_idx;
  } run_desc_t;

  function automatic logic [7:0] run_byte(run_desc_t run, logic [2:0] idx);
    logic [2:0] pos;
    logic [7:0] b;
    pos = idx - 3'd1;
    if (run.entity) begin
      if (idx == 3'd0) begin
        b = AMP_BYTE;
      end else if (idx == run.last_idx) begin
        b = SEMI_BYTE;
      end else begin
        b = ENT_TEXT[run.letter][pos];
      end
    end else if (run.prefix && idx == 3'd0) begin
      b = LEAD_BYTE;
    end else begin
      b = run.data;
    end
    return b;
  endfunction

endpackage

@@ rtl/utf_in_if.sv @@
// ----------------------------------------------------------------------------
// utf_in_if
// Input byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface utf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/utf_out_if.sv @@
// ----------------------------------------------------------------------------
// utf_out_if
// Output byte channel with valid/ready handshake and end-of-run mark.
// ----------------------------------------------------------------------------
interface utf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

@@ rtl/utf_cfg.sv @@
// ----------------------------------------------------------------------------
// utf_cfg
// APB-style register port holding the output form select.
// ----------------------------------------------------------------------------
module utf_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        output_form
);
  import utf_pkg::*;

  logic sel_form;

  assign sel_form = ({paddr[2], 2'b00} == CFG_OUTPUT_FORM);
  assign pready   = 1'b1;
  assign prdata   = sel_form ? {31'd0, output_form} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_form <= 1'b0;
    end else if (psel && penable && pwrite && sel_form) begin
      output_form <= pwdata[0];
    end
  end
endmodule

@@ rtl/utf_decode.sv @@
// ----------------------------------------------------------------------------
// utf_decode
// Classifies an input byte against the held lead and builds the run of
// output bytes it causes.
// ----------------------------------------------------------------------------
module utf_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              output_form,
  output logic              has_run,
  output utf_pkg::run_desc_t desc
);
  import utf_pkg::*;

  logic       lead_pending;
  logic       lead_pending_next;
  logic       hit;
  logic [2:0] letter;

  always_comb begin
    hit    = 1'b0;
    letter = 3'd0;
    for (int k = 0; k < NUM_LETTERS; k++) begin
      if (in_byte == TRAIL_CODE[k]) begin
        hit    = 1'b1;
        letter = 3'(k);
      end
    end
  end

  always_comb begin
    desc              = '0;
    desc.letter       = letter;
    desc.data         = in_byte;
    has_run           = 1'b1;
    lead_pending_next = 1'b0;
    if (lead_pending && hit) begin
      if (output_form) begin
        desc.entity   = 1'b1;
        desc.last_idx = (letter == SZLIG_LETTER) ? ENT_LAST_LONG : ENT_LAST_SHORT;
      end else begin
        desc.data = ISO_CODE[letter];
      end
    end else if (lead_pending) begin
      desc.prefix = 1'b1;
      if (in_byte == LEAD_BYTE) begin
        lead_pending_next = 1'b1;
      end else begin
        desc.last_idx = 3'd1;
      end
    end else if (in_byte == LEAD_BYTE) begin
      has_run           = 1'b0;
      lead_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
    end else if (accept) begin
      lead_pending <= lead_pending_next;
    end
  end
endmodule

@@ rtl/utf_emit.sv @@
// ----------------------------------------------------------------------------
// utf_emit
// Run register and output register: steps through a run one byte per
// transfer and takes the next run as the current one finishes.
// ----------------------------------------------------------------------------
module utf_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               has_run,
  input  utf_pkg::run_desc_t desc,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               run_last
);
  import utf_pkg::*;

  run_desc_t  run;
  logic       run_valid;
  logic [2:0] idx;
  logic       load;
  logic       fin;
  logic       accept;

  assign load     = run_valid && (!out_valid || out_ready);
  assign fin      = load && (idx == run.last_idx);
  assign in_ready = !run_valid || fin;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        run_valid <= has_run;
        idx       <= 3'd0;
      end else if (fin) begin
        run_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run <= desc;
    end
    if (load) begin
      out_byte <= run_byte(run, idx);
      run_last <= (idx == run.last_idx);
    end
  end
endmodule

@@ rtl/utf8_umlaut_transcoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_umlaut_transcoder_top
// Rewrites UTF-8 German umlauts and sharp s as ISO-8859-1 bytes or HTML
// entities, one output byte per transfer.
// ----------------------------------------------------------------------------
// Each input byte is decoded as it is taken into a run register, and the run
// is sent one byte per cycle, while the output is not stalled, through an
// output register. While the output is not stalled, bytes that each cause
// one output byte are accepted in every cycle. A held 0xC3 lead followed by
// a byte that is not a trail byte gives a run of two bytes, or of one byte
// when that byte is another lead. A trail byte after the lead gives one byte
// in ISO-8859-1 form and a run of six or seven bytes in entity form. During a
// run of several bytes the input waits until the last byte of the run is
// loaded into the output register. A lone lead byte gives no output.
// output_form is register 0 at byte address 0.
module utf8_umlaut_transcoder_top (
  input  logic        clk,
  input  logic        rst,
  utf_in_if.sink      in_ch,
  utf_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utf_pkg::*;

  logic      output_form;
  logic      has_run;
  logic      accept;
  run_desc_t desc;

  assign accept = in_ch.valid && in_ch.ready;

  utf_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .output_form (output_form)
  );

  utf_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_ch.in_byte),
    .output_form (output_form),
    .has_run     (has_run),
    .desc        (desc)
  );

  utf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .has_run   (has_run),
    .desc      (desc),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last)
  );
endmodule

@@ rtl/utf_checker.sv @@
// ----------------------------------------------------------------------------
// utf_checker
// Port-level checks on the transcoder's channels over time.
// ----------------------------------------------------------------------------
module utf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output transfer changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !run_last |-> !in_ready)
    else $error("input taken while a stalled run is unfinished");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside an output run");

endmodule

bind utf8_umlaut_transcoder_top utf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_last  (out_ch.run_last)
);
